@@ rtl/digit_sequence_countdown_timer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// digit_sequence_countdown_timer_unit_assert.svh
// assertion macros shared by the countdown timer modules
// ----------------------------------------------------------------------------
`ifndef DIGIT_SEQUENCE_COUNTDOWN_TIMER_UNIT_ASSERT_SVH
`define DIGIT_SEQUENCE_COUNTDOWN_TIMER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define DSCT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DSCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSCT_ASSERT(lbl, clk, rst, prop, msg)
`define DSCT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/dsct_pkg.sv @@
// ----------------------------------------------------------------------------
// dsct_pkg
// types, codes and constants of the digit sequence countdown timer
// ----------------------------------------------------------------------------
package dsct_pkg;

  localparam int NUM_DIGITS_DEF = 11;
  localparam int TIME_BITS_DEF  = 16;

  localparam int CMD_W      = 4;
  localparam int DIGIT_W    = 4;
  localparam int DUR_W      = 16;
  localparam int PASS_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_TICK    = 4'd0;
  localparam logic [CMD_W-1:0] CMD_START   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_RESET   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_STOP    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_PAUSE   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_UP      = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DOWN    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CONFIRM = 4'd7;
  localparam logic [CMD_W-1:0] CMD_TOGGLE  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 4'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_TUBE_TYPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_COUNT = 1'd1;

  localparam logic [PASS_W-1:0] REP_COUNT_RESET = 16'd1;

  localparam int OVR_MAX_TUBE0 = 10;
  localparam int OVR_MAX_TUBE1 = 9;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [DIGIT_W-1:0] digit_index;
    logic [DUR_W-1:0]   duration;
  } item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] shown_digit;
    logic [DUR_W-1:0]   ticks_left;
    logic [PASS_W-1:0]  passes_left;
    logic               is_running;
    logic               is_paused;
    logic               expired_pending;
    logic               expired_acknowledged;
    logic               override_on;
  } result_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_inc;
    logic dec_hit;
    logic pass_end;
    logic out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic tick_scan;
    logic scan_zero;
    logic scan_last;
  } dp_sts_t;

endpackage

@@ rtl/digit_sequence_countdown_timer_unit.sv @@
// ----------------------------------------------------------------------------
// digit_sequence_countdown_timer_unit
// countdown timer over a sequence of digits with repetitions and override
//
//   channel   handshake                 payload
//   item      item_valid / item_ready   item (command, digit_index, duration)
//   result    result_valid / result_ready  result (one word per item)
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a tick that counts scans k = 1..NUM_DIGITS digits, one digit per cycle
// through the scan counter; other commands go from IDLE through EXEC to OUT
// synchronous reset clears flags, counters and all durations, no clearing pass
// a result word waits in the output register; the next item is taken
// meanwhile and holds in the output state until the register is free
// config writes are always taken
// ----------------------------------------------------------------------------
module digit_sequence_countdown_timer_unit #(
  parameter int NUM_DIGITS = dsct_pkg::NUM_DIGITS_DEF,
  parameter int TIME_BITS  = dsct_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  dsct_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output dsct_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dsct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dsct_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  dsct_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .ctl          (ctl)
  );

  dsct_datapath #(
    .NUM_DIGITS (NUM_DIGITS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .result    (result)
  );

endmodule

@@ rtl/dsct_datapath.sv @@
// ----------------------------------------------------------------------------
// dsct_datapath
// digit durations, run flags, config registers, digit scan and result word
// ----------------------------------------------------------------------------
`include "digit_sequence_countdown_timer_unit_assert.svh"

module dsct_datapath #(
  parameter int NUM_DIGITS = 11,
  parameter int TIME_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dsct_pkg::item_t                  item,
  input  logic                             cfg_valid,
  input  logic [dsct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dsct_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  dsct_pkg::dp_ctl_t                ctl,
  output dsct_pkg::dp_sts_t                sts,
  output dsct_pkg::result_t                result
);
  import dsct_pkg::*;

  localparam int DW = $clog2(NUM_DIGITS);
  localparam logic [DW-1:0] LAST = DW'(NUM_DIGITS - 1);
  localparam logic [DIGIT_W:0] DIG_COUNT = (DIGIT_W + 1)'(NUM_DIGITS);
  localparam logic [DW-1:0] OMAX0 =
    (OVR_MAX_TUBE0 > NUM_DIGITS - 1) ? DW'(NUM_DIGITS - 1) : DW'(OVR_MAX_TUBE0);
  localparam logic [DW-1:0] OMAX1 =
    (OVR_MAX_TUBE1 > NUM_DIGITS - 1) ? DW'(NUM_DIGITS - 1) : DW'(OVR_MAX_TUBE1);

  item_t                item_q;
  logic                 tube;
  logic [PASS_W-1:0]    rep_count;
  logic [TIME_BITS-1:0] init_dur [NUM_DIGITS];
  logic [TIME_BITS-1:0] rem_dur  [NUM_DIGITS];
  logic [PASS_W-1:0]    passes;
  logic [DW-1:0]        cur_digit;
  logic [DW-1:0]        ovr_digit;
  logic [DW-1:0]        scan_idx;
  logic                 running;
  logic                 paused;
  logic                 ovr;
  logic                 done;
  logic                 confirmed;

  logic [DW-1:0]        rd_addr;
  logic [TIME_BITS-1:0] rd;
  logic [DW-1:0]        ovr_max;
  logic [TIME_BITS-1:0] wdur;
  logic                 wr_ok;
  logic                 do_start;

  assign rd_addr  = ctl.out_load ? cur_digit : scan_idx;
  assign rd       = rem_dur[rd_addr];
  assign ovr_max  = tube ? OMAX1 : OMAX0;
  assign wdur     = TIME_BITS'(item_q.duration);
  assign wr_ok    = {1'b0, item_q.digit_index} < DIG_COUNT;
  assign do_start = (item_q.command == CMD_START) ||
                    ((item_q.command == CMD_TOGGLE) && !running);

  assign sts.tick_scan = (item_q.command == CMD_TICK) && !ovr && running && !paused;
  assign sts.scan_zero = (rd == '0);
  assign sts.scan_last = (scan_idx == LAST);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_q <= item;
    end
    if (ctl.out_load) begin
      result.shown_digit          <= DIGIT_W'(cur_digit);
      result.ticks_left           <= DUR_W'(rd);
      result.passes_left          <= passes;
      result.is_running           <= running;
      result.is_paused            <= paused;
      result.expired_pending      <= done && !confirmed;
      result.expired_acknowledged <= confirmed;
      result.override_on          <= ovr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tube      <= 1'b0;
      rep_count <= REP_COUNT_RESET;
      for (int d = 0; d < NUM_DIGITS; d++) begin
        init_dur[d] <= '0;
        rem_dur[d]  <= '0;
      end
      passes    <= '0;
      cur_digit <= '0;
      ovr_digit <= '0;
      scan_idx  <= '0;
      running   <= 1'b0;
      paused    <= 1'b0;
      ovr       <= 1'b0;
      done      <= 1'b0;
      confirmed <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TUBE_TYPE: tube      <= cfg_data[0];
          CFG_REP_COUNT: rep_count <= PASS_W'(cfg_data);
          default: ;
        endcase
      end

      if (ctl.exec) begin
        scan_idx <= '0;
        unique case (item_q.command)
          CMD_TICK: begin
            if (ovr) cur_digit <= ovr_digit;
          end
          CMD_RESET: begin
            for (int d = 0; d < NUM_DIGITS; d++) rem_dur[d] <= init_dur[d];
            passes    <= rep_count;
            running   <= 1'b1;
            done      <= 1'b0;
            confirmed <= 1'b0;
            paused    <= 1'b0;
          end
          CMD_STOP: begin
            running <= 1'b0;
            paused  <= 1'b0;
          end
          CMD_PAUSE: paused <= 1'b1;
          CMD_UP: begin
            if (!ovr) begin
              ovr_digit <= cur_digit;
              ovr       <= 1'b1;
            end else if (ovr_digit < ovr_max) begin
              ovr_digit <= ovr_digit + 1'b1;
              cur_digit <= ovr_digit + 1'b1;
            end
          end
          CMD_DOWN: begin
            if (!ovr) begin
              ovr_digit <= cur_digit;
              ovr       <= 1'b1;
            end else if (ovr_digit != '0) begin
              ovr_digit <= ovr_digit - 1'b1;
              cur_digit <= ovr_digit - 1'b1;
            end
          end
          CMD_CONFIRM: confirmed <= 1'b1;
          CMD_TOGGLE: begin
            if (running) begin
              running <= 1'b0;
              paused  <= 1'b0;
            end
          end
          CMD_WRITE: begin
            if (wr_ok) begin
              init_dur[item_q.digit_index[DW-1:0]] <= wdur;
              for (int d = 0; d < NUM_DIGITS; d++) begin
                rem_dur[d] <= (DIGIT_W'(d) == item_q.digit_index) ? wdur : init_dur[d];
              end
            end
          end
          default: ;
        endcase

        if (do_start) begin
          if (ovr) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
              if (DW'(d) < ovr_digit) rem_dur[d] <= '0;
            end
          end
          ovr     <= 1'b0;
          running <= 1'b1;
          paused  <= 1'b0;
        end
      end

      if (ctl.scan_inc) begin
        scan_idx <= scan_idx + 1'b1;
      end

      if (ctl.dec_hit) begin
        rem_dur[scan_idx] <= rd - 1'b1;
        cur_digit         <= scan_idx;
      end

      if (ctl.pass_end) begin
        if (passes > PASS_W'(1)) begin
          passes <= passes - 1'b1;
          for (int d = 0; d < NUM_DIGITS; d++) rem_dur[d] <= init_dur[d];
        end else begin
          running <= 1'b0;
          done    <= 1'b1;
          passes  <= '0;
        end
        cur_digit <= '0;
      end
    end
  end

  `DSCT_ASSERT(a_digits_in_range, clk, rst, (cur_digit <= LAST) && (ovr_digit <= LAST), "digit out of range")
  `DSCT_ASSERT(a_pass_count, clk, rst, (ctl.pass_end && (passes > PASS_W'(1))) |=> (passes == $past(passes) - 1'b1), "pass count not decremented")
  `DSCT_ASSERT(a_hit_digit, clk, rst, ctl.dec_hit |=> (cur_digit == $past(scan_idx)), "shown digit does not follow scan hit")

endmodule

@@ rtl/dsct_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsct_ctrl
// sequencer: takes a word, executes it, scans digits on a tick, emits result
// ----------------------------------------------------------------------------
`include "digit_sequence_countdown_timer_unit_assert.svh"

module dsct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  dsct_pkg::dp_sts_t   sts,
  output dsct_pkg::dp_ctl_t   ctl
);
  import dsct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        ctl.load = item_valid;
        if (item_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = sts.tick_scan ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        if (!sts.scan_zero) begin
          ctl.dec_hit = 1'b1;
          state_next  = S_OUT;
        end else if (sts.scan_last) begin
          ctl.pass_end = 1'b1;
          state_next   = S_OUT;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_OUT: begin
        if (!result_valid || result_ready) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  `DSCT_ASSERT(a_load_exec, clk, rst, ctl.load |=> (state == S_EXEC), "accepted word not executed")
  `DSCT_ASSERT(a_out_valid, clk, rst, ctl.out_load |=> result_valid, "result word lost")
  `DSCT_ASSERT_ALWAYS(a_one_cmd, clk, $onehot0({ctl.load, ctl.exec, ctl.scan_inc, ctl.dec_hit, ctl.pass_end, ctl.out_load}), "more than one datapath command")

endmodule

@@ test/digit_sequence_countdown_timer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digit_sequence_countdown_timer_unit_tb
// self-checking bench for the digit sequence countdown timer
//
// command words are queued by the stimulus process and sent by a clocked
// driver; every accepted word is run through a cycle-free model of the timer
// and the predicted display word is queued. a clocked monitor takes the
// result words under random back pressure and compares them field by field.
// configuration is changed between phases, only once all words are back.
// ----------------------------------------------------------------------------
module digit_sequence_countdown_timer_unit_tb;
  import dsct_pkg::*;

  localparam int NUM = NUM_DIGITS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_ready;
  item_t                 item;
  logic                  result_valid;
  logic                  result_ready;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // timer model state
  logic              cfg_tube;
  logic [PASS_W-1:0] cfg_reps;
  logic [DUR_W-1:0]  dur_init [NUM];
  logic [DUR_W-1:0]  dur_left [NUM];
  logic [PASS_W-1:0] passes;
  logic [3:0]        cur_digit;
  logic [3:0]        ovr_digit;
  logic              running, paused, ovr_mode, done, confirmed;

  item_t   pending_cmds[$];
  result_t predicted_displays[$];
  int      items_queued = 0;
  int      items_counted = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      send_gap = 0;
  int      recv_stall = 0;
  bit      send_gaps_on = 1'b1;
  bit      recv_stalls_on = 1'b1;

  digit_sequence_countdown_timer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic reload_durations();
    int d;
    for (d = 0; d < NUM; d++) dur_left[d] = dur_init[d];
  endtask

  task automatic start_timer();
    int d;
    if (ovr_mode) begin
      for (d = 0; d < NUM; d++) begin
        if (d < ovr_digit) dur_left[d] = '0;
      end
      ovr_mode = 1'b0;
    end
    running = 1'b1;
    paused = 1'b0;
  endtask

  task automatic count_tick();
    int idx;
    idx = 0;
    if (ovr_mode) begin
      cur_digit = ovr_digit;
    end else if (running && !paused) begin
      while (idx < NUM && dur_left[idx] == '0) idx++;
      if (idx >= NUM) begin
        if (passes > 1) begin
          passes = passes - 1'b1;
          reload_durations();
        end else begin
          running = 1'b0;
          done = 1'b1;
          passes = '0;
        end
        cur_digit = '0;
      end else begin
        dur_left[idx] = dur_left[idx] - 1'b1;
        cur_digit = 4'(idx);
      end
    end
  endtask

  task automatic advance_timer(input item_t w, output result_t r);
    int top;
    top = cfg_tube ? OVR_MAX_TUBE1 : OVR_MAX_TUBE0;
    if (top > NUM - 1) top = NUM - 1;
    case (w.command)
      CMD_TICK: count_tick();
      CMD_START: start_timer();
      CMD_RESET: begin
        reload_durations();
        passes = cfg_reps;
        running = 1'b1;
        done = 1'b0;
        confirmed = 1'b0;
        paused = 1'b0;
      end
      CMD_STOP: begin
        running = 1'b0;
        paused = 1'b0;
      end
      CMD_PAUSE: paused = 1'b1;
      CMD_UP: begin
        if (!ovr_mode) begin
          ovr_digit = cur_digit;
          ovr_mode = 1'b1;
        end else if (ovr_digit < top) begin
          ovr_digit = ovr_digit + 1'b1;
          cur_digit = ovr_digit;
        end
      end
      CMD_DOWN: begin
        if (!ovr_mode) begin
          ovr_digit = cur_digit;
          ovr_mode = 1'b1;
        end else if (ovr_digit > 0) begin
          ovr_digit = ovr_digit - 1'b1;
          cur_digit = ovr_digit;
        end
      end
      CMD_CONFIRM: confirmed = 1'b1;
      CMD_TOGGLE: begin
        if (!running) begin
          start_timer();
        end else begin
          running = 1'b0;
          paused = 1'b0;
        end
      end
      CMD_WRITE: begin
        if (w.digit_index < NUM) begin
          dur_init[w.digit_index] = w.duration;
          reload_durations();
        end
      end
      default: ;
    endcase
    r.shown_digit          = cur_digit;
    r.ticks_left           = (cur_digit < NUM) ? dur_left[cur_digit] : '0;
    r.passes_left          = passes;
    r.is_running           = running;
    r.is_paused            = paused;
    r.expired_pending      = done && !confirmed;
    r.expired_acknowledged = confirmed;
    r.override_on          = ovr_mode;
  endtask

  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // driver
  always @(posedge clk) begin
    result_t next_display;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        advance_timer(item, next_display);
        predicted_displays.push_back(next_display);
      end
      if (!item_valid || item_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          item <= pending_cmds.pop_front();
          item_valid <= 1'b1;
          send_gap = pick_gap(send_gaps_on);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_field(input string field, input logic [15:0] want,
                            input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %0d, got %0d", field, want, got);
  endtask

  task automatic check_display(input result_t want, input result_t got);
    if (got.shown_digit !== want.shown_digit)
      flag_field("shown_digit", 16'(want.shown_digit), 16'(got.shown_digit));
    if (got.ticks_left !== want.ticks_left)
      flag_field("ticks_left", want.ticks_left, got.ticks_left);
    if (got.passes_left !== want.passes_left)
      flag_field("passes_left", want.passes_left, got.passes_left);
    if (got.is_running !== want.is_running)
      flag_field("is_running", 16'(want.is_running), 16'(got.is_running));
    if (got.is_paused !== want.is_paused)
      flag_field("is_paused", 16'(want.is_paused), 16'(got.is_paused));
    if (got.expired_pending !== want.expired_pending)
      flag_field("expired_pending", 16'(want.expired_pending),
                 16'(got.expired_pending));
    if (got.expired_acknowledged !== want.expired_acknowledged)
      flag_field("expired_acknowledged", 16'(want.expired_acknowledged),
                 16'(got.expired_acknowledged));
    if (got.override_on !== want.override_on)
      flag_field("override_on", 16'(want.override_on), 16'(got.override_on));
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (predicted_displays.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result word with none predicted: %p", result);
        end else begin
          check_display(predicted_displays.pop_front(), result);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        recv_stall = pick_gap(recv_stalls_on);
      end
    end
  end

  task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [DIGIT_W-1:0] idx,
                            input logic [DUR_W-1:0] dur);
    item_t w;
    w.command = cmd;
    w.digit_index = idx;
    w.duration = dur;
    pending_cmds.push_back(w);
    items_queued++;
    if (cmd <= CMD_WRITE && !(cmd == CMD_WRITE && idx >= NUM)) items_counted++;
  endtask

  task automatic queue_op(input logic [CMD_W-1:0] cmd);
    queue_word(cmd, 4'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_seen != items_queued);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TUBE_TYPE) cfg_tube = val[0];
    else cfg_reps = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return DUR_W'($urandom_range(0, 3));
    if (r < 90) return DUR_W'($urandom_range(4, 20));
    return DUR_W'($urandom);
  endfunction

  // write durations, restart, then mostly ticks
  task automatic queue_run();
    int n, d, r;
    if ($urandom_range(0, 3) == 0) begin
      for (d = 0; d < NUM; d++) queue_word(CMD_WRITE, 4'(d), pick_duration());
    end else begin
      n = $urandom_range(1, 4);
      for (d = 0; d < n; d++)
        queue_word(CMD_WRITE, ($urandom_range(0, 9) == 0) ? 4'($urandom_range(NUM, 15)) :
                   4'($urandom_range(0, NUM - 1)), pick_duration());
    end
    queue_op(($urandom_range(0, 9) != 0) ? CMD_RESET : CMD_START);
    n = $urandom_range(8, 80);
    for (d = 0; d < n; d++) begin
      r = $urandom_range(0, 99);
      if (r < 85) queue_op(CMD_TICK);
      else if (r < 88) queue_op(CMD_PAUSE);
      else if (r < 91) queue_op(CMD_START);
      else if (r < 93) queue_op(CMD_TOGGLE);
      else if (r < 95) queue_op(CMD_CONFIRM);
      else if (r < 97) queue_op(CMD_STOP);
      else queue_op(CMD_RESET);
    end
    if ($urandom_range(0, 1) == 0) queue_op(CMD_CONFIRM);
  endtask

  // manual digit selection, up to and past both clamps, then a start, toggle or tick
  task automatic queue_override();
    int n, d, r;
    n = $urandom_range(0, 13);
    for (d = 0; d < n; d++) queue_op(CMD_UP);
    if ($urandom_range(0, 1) == 0) queue_op(CMD_TICK);
    n = $urandom_range(0, 13);
    for (d = 0; d < n; d++) queue_op(CMD_DOWN);
    n = $urandom_range(0, 13);
    for (d = 0; d < n; d++) queue_op(CMD_UP);
    r = $urandom_range(0, 9);
    if (r < 4) queue_op(CMD_START);
    else if (r < 7) queue_op(CMD_TOGGLE);
    else queue_op(CMD_TICK);
    n = $urandom_range(0, 5);
    for (d = 0; d < n; d++) queue_op(CMD_TICK);
  endtask

  task automatic queue_noise();
    int n, d;
    n = $urandom_range(1, 6);
    for (d = 0; d < n; d++)
      queue_word(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 16'($urandom));
  endtask

  initial begin
    int p, k, target, r;
    logic [PASS_W-1:0] reps;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_tube = 1'b0;
    cfg_reps = REP_COUNT_RESET;
    for (k = 0; k < NUM; k++) begin
      dur_init[k] = '0;
      dur_left[k] = '0;
    end
    passes = '0;
    cur_digit = '0;
    ovr_digit = '0;
    {running, paused, ovr_mode, done, confirmed} = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed words on reset configuration
    queue_word(CMD_TICK, 4'd0, 16'd0);
    queue_word(CMD_UNUSED_HI, 4'd15, 16'hFFFF);
    queue_word(CMD_WRITE, 4'd15, 16'hFFFF);
    queue_word(CMD_WRITE, 4'd0, 16'd1);
    queue_word(CMD_WRITE, 4'd1, 16'hFFFF);
    queue_word(CMD_RESET, 4'd0, 16'd0);
    queue_word(CMD_TICK, 4'd0, 16'd0);
    queue_word(CMD_PAUSE, 4'd0, 16'd0);
    queue_word(CMD_TICK, 4'd0, 16'd0);
    queue_word(CMD_TOGGLE, 4'd0, 16'd0);
    queue_word(CMD_TOGGLE, 4'd0, 16'd0);
    queue_word(CMD_TICK, 4'd0, 16'd0);
    queue_word(CMD_DOWN, 4'd0, 16'd0);
    queue_word(CMD_DOWN, 4'd0, 16'd0);
    queue_word(CMD_DOWN, 4'd0, 16'd0);
    queue_word(CMD_TICK, 4'd0, 16'd0);
    queue_word(CMD_UP, 4'd0, 16'd0);
    queue_word(CMD_START, 4'd0, 16'd0);
    queue_word(CMD_CONFIRM, 4'd0, 16'd0);
    queue_word(CMD_STOP, 4'd0, 16'd0);
    queue_word(CMD_WRITE, 4'd1, 16'd0);
    queue_word(CMD_RESET, 4'd0, 16'd0);
    queue_word(CMD_TICK, 4'd0, 16'd0);
    queue_word(CMD_CONFIRM, 4'd0, 16'd0);
    queue_word(CMD_UNUSED_LO, 4'd0, 16'd0);

    // random phases, configuration changed while drained
    p = 0;
    while (items_counted < 2025) begin
      wait_drained();
      if (p < 2) begin
        k = (p == 0) ? 1 : 0;
      end else begin
        k = $urandom_range(0, 1);
      end
      write_reg(CFG_TUBE_TYPE, {15'($urandom), 1'(k)});
      r = $urandom_range(0, 99);
      case (p)
        0: reps = '0;
        1: reps = '1;
        2: reps = 16'd1;
        3: reps = 16'd2;
        default: begin
          if (r < 80) reps = PASS_W'($urandom_range(0, 3));
          else if (r < 95) reps = PASS_W'($urandom_range(4, 16));
          else reps = PASS_W'($urandom);
        end
      endcase
      write_reg(CFG_REP_COUNT, reps);
      send_gaps_on = (p % 4 != 3);
      recv_stalls_on = (p % 4 != 2);
      target = items_counted + 200;
      while (items_counted < target) begin
        r = $urandom_range(0, 99);
        if (r < 55) queue_run();
        else if (r < 80) queue_override();
        else queue_noise();
      end
      p++;
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && predicted_displays.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d words outstanding", items_queued - results_seen);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
